@@ rtl/core/bil_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg
// Shared types and byte codes for the bencode info span locator.
// ----------------------------------------------------------------------------
package bil_pkg;

    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0]  INFO_LEN  = 3'd4;
    localparam logic [31:0] INFO_LEN32 = 32'd4;

    typedef enum logic [3:0] {
        PH_EXPECT_D,
        PH_KEY_LEN,
        PH_KEY_BYTES,
        PH_ITEM,
        PH_INT_FIRST,
        PH_INT_DIGITS,
        PH_STR_LEN,
        PH_STR_BYTES,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        NS_LIST,
        NS_DICT_KEY,
        NS_DICT_VAL
    } nest_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] offset;
        logic [31:0] acc;
        logic [31:0] remain;
        logic [2:0]  match;
        logic        is_info;
        logic [31:0] vstart;
    } scan_state_t;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] start;
        logic [31:0] length;
    } report_t;

    function automatic logic [7:0] info_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h69;
            2'd1:    c = 8'h6e;
            2'd2:    c = 8'h66;
            default: c = 8'h6f;
        endcase
        return c;
    endfunction

    function automatic nest_t nest_flip(input nest_t n);
        nest_t r;
        case (n)
            NS_DICT_KEY: r = NS_DICT_VAL;
            NS_DICT_VAL: r = NS_DICT_KEY;
            default:     r = n;
        endcase
        return r;
    endfunction

    localparam scan_state_t SCAN_RESET = '{
        phase:   PH_EXPECT_D,
        offset:  32'd0,
        acc:     32'd0,
        remain:  32'd0,
        match:   3'd0,
        is_info: 1'b0,
        vstart:  32'd0
    };

endpackage

@@ rtl/core/bencode_info_span_locator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_info_span_locator
// Scans a bencoded blob byte by byte and reports the span of the value of
// the top-level "info" key, or not found.
// ----------------------------------------------------------------------------
// Output: a result's last byte is registered in the input stage and the result
// in the output stage. Throughput: one byte per cycle, set by the combinational
// parser update and the nesting stack RAM (one write, one registered read per
// cycle), while no pending result stalls on out_ready.
// Reset: rst_n clears the parser state and both handshake stages at once;
// the nesting stack RAM is not cleared.
// ----------------------------------------------------------------------------
module bencode_info_span_locator #(
    parameter int MAX_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  blob_byte,
    input  logic        blob_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] span_start,
    output logic [31:0] span_length
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic                 in_vld_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 go;

    bil_pkg::scan_state_t state_reg;
    bil_pkg::scan_state_t state_next;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [DEPTH_W-1:0]   depth_eff;
    bil_pkg::nest_t       top_reg;
    bil_pkg::nest_t       top_next;
    bil_pkg::nest_t       below;
    logic                 stack_wr;
    logic                 byp_reg;
    bil_pkg::nest_t       byp_data_reg;
    logic [1:0]           ram_rd;
    bil_pkg::report_t     rep;

    logic                 out_vld_reg;
    logic                 found_reg;
    logic [31:0]          start_reg;
    logic [31:0]          length_reg;

    assign go       = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= blob_byte;
            last_reg <= blob_last;
        end
    end

    bil_step #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_step (
        .cur        (state_reg),
        .depth      (depth_reg),
        .top        (top_reg),
        .below      (below),
        .blob_byte  (byte_reg),
        .blob_last  (last_reg),
        .nxt        (state_next),
        .depth_next (depth_next),
        .top_next   (top_next),
        .stack_wr   (stack_wr),
        .rep        (rep)
    );

    // entries below the top live in RAM; the top is held in a register
    assign depth_eff = go ? depth_next : depth_reg;
    assign below     = byp_reg ? byp_data_reg : bil_pkg::nest_t'(ram_rd);

    bil_ram #(
        .WIDTH(2),
        .DEPTH(MAX_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (go && stack_wr),
        .wr_addr (ADDR_W'(depth_reg - DEPTH_W'(1))),
        .wr_data (top_reg),
        .rd_addr (ADDR_W'(depth_eff - DEPTH_W'(2))),
        .rd_data (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bil_pkg::SCAN_RESET;
            depth_reg <= '0;
            top_reg   <= bil_pkg::NS_LIST;
            byp_reg   <= 1'b0;
        end
        else
        begin
            byp_reg <= go && stack_wr;
            if (go)
            begin
                state_reg <= state_next;
                depth_reg <= depth_next;
                top_reg   <= top_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (go && rep.valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && rep.valid)
        begin
            found_reg  <= rep.found;
            start_reg  <= rep.start;
            length_reg <= rep.length;
        end
    end

    assign out_valid   = out_vld_reg;
    assign found       = found_reg;
    assign span_start  = start_reg;
    assign span_length = length_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth above bound");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && last_reg |=> (state_reg.phase == bil_pkg::PH_EXPECT_D) &&
                           (state_reg.offset == 32'd0) && (depth_reg == '0))
        else $error("parser not cleared after last byte");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !found_reg |-> (start_reg == 32'd0) && (length_reg == 32'd0))
        else $error("not-found transaction carries a span");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg && $stable(start_reg) &&
                                      $stable(length_reg))
        else $error("pending result overwritten");
`endif

endmodule

@@ rtl/core/bil_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bil_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/bil_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_step
// Per-byte parser update: next scan state, nesting stack moves and report.
// ----------------------------------------------------------------------------
module bil_step #(
    parameter int MAX_DEPTH = 32,
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1)
) (
    input  bil_pkg::scan_state_t cur,
    input  logic [DEPTH_W-1:0]   depth,
    input  bil_pkg::nest_t       top,
    input  bil_pkg::nest_t       below,
    input  logic [7:0]           blob_byte,
    input  logic                 blob_last,
    output bil_pkg::scan_state_t nxt,
    output logic [DEPTH_W-1:0]   depth_next,
    output bil_pkg::nest_t       top_next,
    output logic                 stack_wr,
    output bil_pkg::report_t     rep
);

    logic [35:0] acc10;
    logic        acc_ovf;
    logic        is_digit;
    logic [31:0] off1;
    logic        vdone;
    logic        popped;
    logic        fail;
    logic        rep_hit;
    logic        rep_found;
    bil_pkg::nest_t tsrc;

    assign off1     = cur.offset + 32'd1;
    assign is_digit = (blob_byte >= bil_pkg::CH_ZERO) && (blob_byte <= bil_pkg::CH_NINE);
    assign acc10    = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + 36'(blob_byte[3:0]);
    assign acc_ovf  = |acc10[35:32];

    // next state
    always_comb
    begin
        nxt        = cur;
        nxt.offset = off1;
        depth_next = depth;
        top_next   = top;
        stack_wr   = 1'b0;
        vdone      = 1'b0;
        popped     = 1'b0;
        fail       = 1'b0;
        rep_hit    = 1'b0;
        rep_found  = 1'b0;
        tsrc       = top;

        case (cur.phase)
            bil_pkg::PH_EXPECT_D:
            begin
                if (blob_byte == bil_pkg::CH_D)
                begin
                    nxt.phase = bil_pkg::PH_KEY_LEN;
                    nxt.acc   = 32'd0;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            bil_pkg::PH_KEY_LEN:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        nxt.acc = acc10[31:0];
                    end
                end
                else if (blob_byte == bil_pkg::CH_COLON)
                begin
                    nxt.remain  = cur.acc;
                    nxt.match   = 3'd0;
                    nxt.is_info = (cur.acc == bil_pkg::INFO_LEN32);
                    if (cur.acc == 32'd0)
                    begin
                        nxt.vstart = off1;
                        nxt.phase  = bil_pkg::PH_ITEM;
                    end
                    else
                    begin
                        nxt.phase = bil_pkg::PH_KEY_BYTES;
                    end
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            bil_pkg::PH_KEY_BYTES:
            begin
                if (cur.match < bil_pkg::INFO_LEN)
                begin
                    if (blob_byte != bil_pkg::info_char(cur.match[1:0]))
                    begin
                        nxt.is_info = 1'b0;
                    end
                    nxt.match = cur.match + 3'd1;
                end
                nxt.remain = cur.remain - 32'd1;
                if (cur.remain == 32'd1)
                begin
                    nxt.vstart = off1;
                    nxt.phase  = bil_pkg::PH_ITEM;
                end
            end
            bil_pkg::PH_ITEM:
            begin
                if (blob_byte == bil_pkg::CH_I)
                begin
                    nxt.phase = bil_pkg::PH_INT_FIRST;
                end
                else if (is_digit)
                begin
                    nxt.acc   = 32'(blob_byte[3:0]);
                    nxt.phase = bil_pkg::PH_STR_LEN;
                end
                else if ((blob_byte == bil_pkg::CH_L) || (blob_byte == bil_pkg::CH_D))
                begin
                    if (depth == DEPTH_W'(MAX_DEPTH))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        stack_wr   = (depth != '0);
                        top_next   = (blob_byte == bil_pkg::CH_L) ? bil_pkg::NS_LIST
                                                                  : bil_pkg::NS_DICT_KEY;
                        depth_next = depth + DEPTH_W'(1);
                    end
                end
                else if ((blob_byte == bil_pkg::CH_E) && (depth != '0) &&
                         (top != bil_pkg::NS_DICT_VAL))
                begin
                    depth_next = depth - DEPTH_W'(1);
                    popped     = 1'b1;
                    vdone      = 1'b1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            bil_pkg::PH_INT_FIRST,
            bil_pkg::PH_INT_DIGITS:
            begin
                if (blob_byte == bil_pkg::CH_E)
                begin
                    vdone = 1'b1;
                end
                else if (is_digit || ((blob_byte == bil_pkg::CH_MINUS) &&
                                      (cur.phase == bil_pkg::PH_INT_FIRST)))
                begin
                    nxt.phase = bil_pkg::PH_INT_DIGITS;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            bil_pkg::PH_STR_LEN:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        nxt.acc = acc10[31:0];
                    end
                end
                else if (blob_byte == bil_pkg::CH_COLON)
                begin
                    if (cur.acc == 32'd0)
                    begin
                        vdone = 1'b1;
                    end
                    else
                    begin
                        nxt.remain = cur.acc;
                        nxt.phase  = bil_pkg::PH_STR_BYTES;
                    end
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            bil_pkg::PH_STR_BYTES:
            begin
                nxt.remain = cur.remain - 32'd1;
                if (cur.remain == 32'd1)
                begin
                    vdone = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // end of a value
        if (vdone)
        begin
            if (depth_next == '0)
            begin
                if (cur.is_info)
                begin
                    rep_hit   = 1'b1;
                    rep_found = 1'b1;
                    nxt.phase = bil_pkg::PH_DONE;
                end
                else
                begin
                    nxt.phase = bil_pkg::PH_KEY_LEN;
                    nxt.acc   = 32'd0;
                end
            end
            else
            begin
                tsrc      = popped ? below : top;
                top_next  = bil_pkg::nest_flip(tsrc);
                nxt.phase = bil_pkg::PH_ITEM;
            end
        end

        if (fail)
        begin
            rep_hit   = 1'b1;
            nxt.phase = bil_pkg::PH_DONE;
        end

        if (blob_last)
        begin
            if (cur.phase != bil_pkg::PH_DONE)
            begin
                rep_hit = 1'b1;
            end
            nxt        = bil_pkg::SCAN_RESET;
            depth_next = '0;
        end
    end

    // report
    always_comb
    begin
        rep.valid  = rep_hit;
        rep.found  = rep_found;
        rep.start  = rep_found ? cur.vstart : 32'd0;
        rep.length = rep_found ? (off1 - cur.vstart) : 32'd0;
    end

endmodule
